// ----- hdl/oots_pkg.sv -----
// Package for the on/off traffic source bank: codes, structs and the LFSR step function.
package oots_pkg;

  // Default bank geometry and draw settings.
  localparam int NumSourcesDef   = 64;
  localparam int MaxDrawsDef     = 256;
  localparam int FractionBitsDef = 16;

  // Threshold registers are 16-bit fractions.
  localparam int ThreshBits = 16;

  // Fixed register widths.
  localparam int CfgIdxW   = 3;
  localparam int CfgDataW  = 64;
  localparam int SrcCountW = 7;
  localparam int IdxW      = 6;
  localparam int PatternW  = 64;
  localparam int StatusW   = 2;

  // Galois LFSR, x^32+x^22+x^2+x+1, right shifting.
  localparam logic [31:0] LfsrToggle = 32'h8020_0003;
  localparam int LfsrStepsPerCycle   = 8;
  localparam int LfsrStepW           = 4;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_LEAVE   = 3'd0,
    CFG_ENTER   = 3'd1,
    CFG_EXT     = 3'd2,
    CFG_SOURCES = 3'd3,
    CFG_PATTERN = 3'd4,
    CFG_SEED    = 3'd5
  } cfg_reg_e;

  typedef enum logic [StatusW-1:0] {
    STATUS_OFF        = 2'd0,
    STATUS_ON         = 2'd1,
    STATUS_ON_CHANGED = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_DRAW,
    ST_FINISH
  } ctrl_state_e;

  // Control of the source memory.
  typedef struct packed {
    logic rd_en;
    logic we;
    logic restore;
  } mem_ctrl_t;

  // Control and status of the draw unit.
  typedef struct packed {
    logic start;
    logic load;
  } drw_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } drw_stat_t;

  // Advance the LFSR by n steps, n at most LfsrStepsPerCycle.
  function automatic logic [31:0] lfsr_adv(logic [31:0] s, logic [LfsrStepW-1:0] n);
    logic [31:0] r;
    r = s;
    for (int k = 0; k < LfsrStepsPerCycle; k++) begin
      if (LfsrStepW'(k) < n) begin
        r = r[0] ? ({1'b0, r[31:1]} ^ LfsrToggle) : {1'b0, r[31:1]};
      end
    end
    return r;
  endfunction

endpackage

// ----- hdl/on_off_traffic_source_bank_unit.sv -----
// Top level of the on/off traffic source bank: configuration, control sequencer, result register.
//
// A bank of two-state Markov on/off sources, one bit each, held in a synchronous memory
// of min(NUM_SOURCES, 64) one-bit entries. An inject word (tuser 0) names a source in
// tdata; the block reads its bit, draws a FRACTION_BITS fraction from a 32-bit Galois
// LFSR and writes the new bit back. An on source stays on when the draw is at least
// leave_threshold; an off source turns on when the draw is below enter_threshold. With
// extended_mode set the block keeps drawing until a draw leaves the bit unchanged or
// MAX_DRAWS draws are made, and reports "on after change" if the source ends on and any
// draw turned it on. A restore word (tuser 1) reloads initial_pattern and generator_seed
// and returns a result word of zeros; a source at or above sources_in_use (or the bank
// size) returns the invalid flag and changes nothing. New pattern and seed values take
// effect at the next restore; thresholds and mode apply at once. Restore costs no sweep:
// entries carry written-since-restore marks and unmarked entries read from a snapshot of
// the pattern. An inject runs from accept through ST_READ, where the stored bit is
// taken and the first draw starts, and ST_DRAW, where the LFSR advances up to eight steps
// per cycle, to ST_FINISH; restore and invalid words go straight to ST_FINISH.
// One word is worked at a time; a new word is taken while the previous result waits in
// the output register, and the block holds at its end if that result is still not taken.
module on_off_traffic_source_bank_unit
  import oots_pkg::*;
#(
  parameter int NUM_SOURCES   = NumSourcesDef,
  parameter int MAX_DRAWS     = MaxDrawsDef,
  parameter int FRACTION_BITS = FractionBitsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // Configuration write port.
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  // Request stream.
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  input  logic [7:0]          s_axis_tdata_i,   // [5:0] source_index, [7:6] zero
  input  logic                s_axis_tuser_i,   // [0] mode
  // Result stream.
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  output logic [7:0]          m_axis_tdata_o    // [1:0] injection_status, [2] source_invalid,
                                                // [3] draw_limit_hit, [7:4] zero
);

  // Only indices below 64 can be named, so deeper entries would never be touched.
  localparam int SrcDepth = (NUM_SOURCES < 64) ? NUM_SOURCES : 64;
  localparam int SrcAw    = (SrcDepth > 1) ? $clog2(SrcDepth) : 1;
  localparam int DrawCntW = (MAX_DRAWS > 1) ? $clog2(MAX_DRAWS) : 1;
  localparam int ScW      = FRACTION_BITS + ThreshBits;

  // Configuration registers.
  logic [ThreshBits-1:0] leave_q;
  logic [ThreshBits-1:0] enter_q;
  logic                  ext_q;
  logic [SrcCountW-1:0]  sources_q;
  logic [PatternW-1:0]   pattern_q;
  logic [31:0]           seed_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      leave_q   <= '0;
      enter_q   <= '0;
      ext_q     <= 1'b0;
      sources_q <= SrcCountW'(64);
      pattern_q <= '0;
      seed_q    <= 32'd1;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_LEAVE:   leave_q   <= cfg_wdata_i[ThreshBits-1:0];
        CFG_ENTER:   enter_q   <= cfg_wdata_i[ThreshBits-1:0];
        CFG_EXT:     ext_q     <= cfg_wdata_i[0];
        CFG_SOURCES: sources_q <= cfg_wdata_i[SrcCountW-1:0];
        CFG_PATTERN: pattern_q <= cfg_wdata_i[PatternW-1:0];
        CFG_SEED:    seed_q    <= cfg_wdata_i[31:0];
        default:     ;  // drop writes beyond the register list
      endcase
    end
  end

  // Sequencer and work registers.
  ctrl_state_e           state_q, state_d;
  logic [IdxW-1:0]       idx_q;
  logic                  wb_q;
  logic                  cur_q;
  logic                  chg_q;
  logic [DrawCntW-1:0]   n_q;
  logic [StatusW-1:0]    res_status_q;
  logic                  res_invalid_q;
  logic                  res_hit_q;
  logic                  m_valid_q;
  logic [7:0]            m_data_q;

  mem_ctrl_t                mem_ctrl;
  drw_ctrl_t                drw_ctrl;
  drw_stat_t                drw_stat;
  logic                     mem_rd;
  logic [FRACTION_BITS-1:0] fraction;

  logic            in_acc;
  logic            req_inv;
  logic            req_inject;
  logic [IdxW-1:0] idx_in;
  logic [ScW-1:0]  d_sc, leave_sc, enter_sc;
  logic            nxt_bit;
  logic            settle;
  logic            at_lim;
  logic            stop;
  logic            chg_nxt;
  logic            out_free;

  assign idx_in   = s_axis_tdata_i[IdxW-1:0];
  assign in_acc   = s_axis_tvalid_i && s_axis_tready_o;
  // A count above the bank acts as the bank size; zero makes every source invalid.
  assign req_inv  = ({1'b0, idx_in} >= sources_q) || (int'(idx_in) >= NUM_SOURCES);
  assign req_inject = !s_axis_tuser_i && !req_inv;

  // Scale draw and thresholds to a common denominator so the compare is exact.
  assign d_sc     = {fraction, {ThreshBits{1'b0}}};
  assign leave_sc = {leave_q, {FRACTION_BITS{1'b0}}};
  assign enter_sc = {enter_q, {FRACTION_BITS{1'b0}}};
  assign nxt_bit  = cur_q ? (d_sc >= leave_sc) : (d_sc < enter_sc);
  assign settle   = !ext_q || (nxt_bit == cur_q);
  assign at_lim   = (n_q == DrawCntW'(MAX_DRAWS - 1));
  assign stop     = settle || at_lim;
  assign chg_nxt  = chg_q || (!cur_q && nxt_bit);
  assign out_free = !m_valid_q || m_axis_tready_i;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          state_d = req_inject ? ST_READ : ST_FINISH;
        end
      end
      ST_READ: begin
        state_d = ST_DRAW;
      end
      ST_DRAW: begin
        if (drw_stat.done && stop) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    s_axis_tready_o  = (state_q == ST_IDLE);
    mem_ctrl.rd_en   = in_acc && req_inject;
    mem_ctrl.restore = in_acc && s_axis_tuser_i;
    mem_ctrl.we      = (state_q == ST_FINISH) && out_free && wb_q;
    drw_ctrl.load    = in_acc && s_axis_tuser_i;
    // Chain the next draw straight off the one just finished.
    drw_ctrl.start   = (state_q == ST_READ) ||
                       ((state_q == ST_DRAW) && drw_stat.done && !stop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Work registers: no reset needed, each is loaded before it is used.
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          idx_q         <= idx_in;
          wb_q          <= req_inject;
          res_status_q  <= STATUS_OFF;
          res_invalid_q <= req_inv && !s_axis_tuser_i;
          res_hit_q     <= 1'b0;
        end
      end
      ST_READ: begin
        cur_q <= mem_rd;
        chg_q <= 1'b0;
        n_q   <= '0;
      end
      ST_DRAW: begin
        if (drw_stat.done) begin
          cur_q <= nxt_bit;
          chg_q <= chg_nxt;
          if (stop) begin
            if (!nxt_bit) begin
              res_status_q <= STATUS_OFF;
            end else if (ext_q && chg_nxt) begin
              res_status_q <= STATUS_ON_CHANGED;
            end else begin
              res_status_q <= STATUS_ON;
            end
            res_hit_q <= ext_q && (nxt_bit != cur_q);
          end else begin
            n_q <= n_q + DrawCntW'(1);
          end
        end
      end
      default: ;
    endcase
  end

  // Output register: load at the end of a word, hold while the sink stalls.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if ((state_q == ST_FINISH) && out_free) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == ST_FINISH) && out_free) begin
      m_data_q <= {4'b0000, res_hit_q, res_invalid_q, res_status_q};
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

  oots_src_mem #(
    .Depth (SrcDepth),
    .Aw    (SrcAw)
  ) u_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (mem_ctrl),
    .addr_i    ((state_q == ST_IDLE) ? idx_in[SrcAw-1:0] : idx_q[SrcAw-1:0]),
    .wdata_i   (cur_q),
    .pattern_i (pattern_q[SrcDepth-1:0]),
    .rdata_o   (mem_rd)
  );

  oots_draw #(
    .FractionBits (FRACTION_BITS)
  ) u_draw (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (drw_ctrl),
    .seed_i     (seed_q),
    .stat_o     (drw_stat),
    .fraction_o (fraction)
  );

`ifndef SYNTH
  // The LFSR does not advance whenever a new word may be taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready_o |-> !drw_stat.busy)
    else $error("draw unit busy while idle");

  // A result appears only out of the finishing state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(state_q == ST_FINISH))
    else $error("result raised outside the finishing state");

  // Write-back happens only for a valid inject.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_ctrl.we |-> (wb_q && !res_invalid_q))
    else $error("memory write for a word without write-back");
`endif

endmodule

// ----- hdl/oots_src_mem.sv -----
// On/off bit store: synchronous memory plus restore snapshot and written-since-restore marks.
module oots_src_mem
  import oots_pkg::*;
#(
  parameter int Depth = 64,
  parameter int Aw    = 6
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  mem_ctrl_t        ctrl_i,
  input  logic [Aw-1:0]    addr_i,
  input  logic             wdata_i,
  input  logic [Depth-1:0] pattern_i,
  output logic             rdata_o
);

  logic             mem_q [Depth];
  logic             mem_rd_q;
  logic [Aw-1:0]    addr_q;
  logic [Depth-1:0] valid_q;
  logic [Depth-1:0] snap_q;

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.we) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (ctrl_i.rd_en) begin
      mem_rd_q <= mem_q[addr_i];
      addr_q   <= addr_i;
    end
  end

  // A restore drops every mark; an unmarked entry reads from the snapshot.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      snap_q  <= '0;
    end else if (ctrl_i.restore) begin
      valid_q <= '0;
      snap_q  <= pattern_i;
    end else if (ctrl_i.we) begin
      valid_q[addr_i] <= 1'b1;
    end
  end

  assign rdata_o = valid_q[addr_q] ? mem_rd_q : snap_q[addr_q];

endmodule

// ----- hdl/oots_draw.sv -----
// Draw unit: the 32-bit LFSR advanced a few steps per cycle until one fraction is drawn.
module oots_draw
  import oots_pkg::*;
#(
  parameter int FractionBits = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  drw_ctrl_t               ctrl_i,
  input  logic [31:0]             seed_i,
  output drw_stat_t               stat_o,
  output logic [FractionBits-1:0] fraction_o
);

  localparam int RemW = $clog2(FractionBits + 1);

  logic [31:0]          lfsr_q;
  logic [RemW-1:0]      rem_q;
  logic                 busy_q;
  logic                 done_q;
  logic [LfsrStepW-1:0] step;

  always_comb begin
    if (rem_q > RemW'(LfsrStepsPerCycle)) begin
      step = LfsrStepW'(LfsrStepsPerCycle);
    end else begin
      step = LfsrStepW'(rem_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lfsr_q <= 32'd1;
      rem_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (ctrl_i.load) begin
        // Lift a zero seed to one so the register never locks up.
        lfsr_q <= (seed_i == 32'd0) ? 32'd1 : seed_i;
      end else if (ctrl_i.start) begin
        busy_q <= 1'b1;
        rem_q  <= RemW'(FractionBits);
      end else if (busy_q) begin
        lfsr_q <= lfsr_adv(lfsr_q, step);
        rem_q  <= rem_q - RemW'(step);
        if (rem_q == RemW'(step)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign fraction_o  = lfsr_q[FractionBits-1:0];

endmodule
